@@ src/kmvp_pkg.sv @@
// Shared constants, types and arithmetic helpers for the Kronecker product core.
package kmvp_pkg;

   localparam int MAX_DIM    = 8;
   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   localparam int DIM_W     = $clog2(MAX_DIM + 1);
   localparam int MAT_DEPTH = MAX_DIM * MAX_DIM;
   localparam int VEC_DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
   localparam int MAT_AW    = $clog2(MAT_DEPTH);
   localparam int VEC_AW    = $clog2(VEC_DEPTH);
   localparam int PROD_W    = 2 * DATA_WIDTH;
   localparam int ACC_W     = PROD_W + DIM_W + 1;

   localparam logic [2:0] OP_WRITE_A1 = 3'd0;
   localparam logic [2:0] OP_WRITE_A2 = 3'd1;
   localparam logic [2:0] OP_WRITE_A3 = 3'd2;
   localparam logic [2:0] OP_WRITE_X  = 3'd3;
   localparam logic [2:0] OP_COMPUTE  = 3'd4;
   localparam logic [2:0] OP_READ_Y   = 3'd5;

   localparam logic [1:0] ST_READ_DATA = 2'd0;
   localparam logic [1:0] ST_COMPUTED  = 2'd1;
   localparam logic [1:0] ST_RANGE_ERR = 2'd2;

   localparam logic [2:0] REG_FACTOR_COUNT = 3'd0;
   localparam logic [2:0] REG_FIRST_ROWS   = 3'd1;
   localparam logic [2:0] REG_FIRST_COLS   = 3'd2;
   localparam logic [2:0] REG_SECOND_ROWS  = 3'd3;
   localparam logic [2:0] REG_SECOND_COLS  = 3'd4;
   localparam logic [2:0] REG_THIRD_ROWS   = 3'd5;
   localparam logic [2:0] REG_THIRD_COLS   = 3'd6;

   typedef logic signed [DATA_WIDTH-1:0] data_type;

   // clamp a raw 4-bit register to 1..MAX_DIM
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [3:0] v);
      logic [DIM_W-1:0] r;
      if (v == 4'd0) r = DIM_W'(1);
      else if (32'(v) > MAX_DIM) r = DIM_W'(MAX_DIM);
      else r = DIM_W'(v);
      return r;
   endfunction

   // saturate a 32-bit signed input to DATA_WIDTH
   function automatic data_type sat_in(input logic signed [31:0] v);
      logic signed [63:0] w;
      logic signed [63:0] mx;
      logic signed [63:0] mn;
      w  = 64'(v);
      mx = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
      mn = -mx - 64'sd1;
      if (w > mx) return DATA_WIDTH'(mx);
      else if (w < mn) return DATA_WIDTH'(mn);
      return DATA_WIDTH'(w);
   endfunction

   // shift the accumulator down and saturate to DATA_WIDTH
   function automatic data_type shift_sat(input logic signed [ACC_W-1:0] a);
      logic signed [ACC_W-1:0] s;
      logic signed [ACC_W-1:0] mx;
      logic signed [ACC_W-1:0] mn;
      s  = a >>> FRAC_BITS;
      mx = (ACC_W'(1) <<< (DATA_WIDTH - 1)) - ACC_W'(1);
      mn = -mx - ACC_W'(1);
      if (s > mx) return DATA_WIDTH'(mx);
      else if (s < mn) return DATA_WIDTH'(mn);
      return DATA_WIDTH'(s);
   endfunction

   typedef struct packed {
      logic              three;
      logic [DIM_W-1:0]  r1, c1, r2, c2, r3, c3;
   } seq_ctl_type;

endpackage

@@ src/kmvp_mac.sv @@
// Shared multiply-accumulate unit: registered product, then accumulate.
module kmvp_mac (
   input  logic                           clock,
   input  logic                           clear,
   input  logic                           valid,
   input  kmvp_pkg::data_type             a,
   input  kmvp_pkg::data_type             b,
   output logic signed [kmvp_pkg::ACC_W-1:0] acc
);
   import kmvp_pkg::*;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     pv_ff, pv_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   always_comb begin
      prod_in = PROD_W'(a) * PROD_W'(b);
      pv_in   = valid;
      acc_in  = clear ? '0 : (pv_ff ? acc_ff + ACC_W'(prod_ff) : acc_ff);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      pv_ff   <= pv_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;
endmodule

@@ src/kronecker_matrix_vector_product_core.sv @@
// Top level: stores, stage sequencer and request/response channels.
//  channel | dir  | beat
//  req_    | in   | opcode, elem_index, elem_value
//  rsp_    | out  | out_value, out_index, status
//  csr_    | in   | write enable, index, data
// A read in range raises req_stall while its registered lookup of the y store completes.
// A compute item runs the shared multiply-accumulate unit over every stage:
// each output element passes through fetch, drain and store; each stage opens with a set-up
// state, and the done state posts the reply; req_stall stays high throughout.
// Reset is synchronous; stores hold no reset value. A stalled response holds.
module kronecker_matrix_vector_product_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [8:0]  req_elem_index,
   input  logic signed [31:0] req_elem_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_out_value,
   output logic [8:0]  rsp_out_index,
   output logic [1:0]  rsp_status,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [3:0]  csr_data
);
   import kmvp_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SETUP = 6'b000010,
      S_FETCH = 6'b000100,
      S_DRAIN = 6'b001000,
      S_STORE = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [1:0] fc_ff;
   logic [3:0] r1_ff, c1_ff, r2_ff, c2_ff, r3_ff, c3_ff;

   data_type mem_a1 [MAT_DEPTH];
   data_type mem_a2 [MAT_DEPTH];
   data_type mem_a3 [MAT_DEPTH];
   data_type mem_x  [VEC_DEPTH];
   data_type mem_p  [VEC_DEPTH];
   data_type mem_q  [VEC_DEPTH];
   data_type mem_y  [VEC_DEPTH];

   logic     rv_ff, rv_in;
   data_type rval_ff, rval_in;
   logic [8:0] ridx_ff, ridx_in;
   logic [1:0] rst_ff, rst_in;
   logic     rd_pend_ff, rd_pend_in;
   data_type y_rd_ff;

   seq_ctl_type ctl;
   logic [DIM_W-1:0] r1, c1, r2, c2, r3, c3;
   assign r1 = clamp_dim(r1_ff);
   assign c1 = clamp_dim(c1_ff);
   assign r2 = clamp_dim(r2_ff);
   assign c2 = clamp_dim(c2_ff);
   assign r3 = clamp_dim(r3_ff);
   assign c3 = clamp_dim(c3_ff);

   // stage: 0 first (last factor), 1, 2
   logic [1:0] stg_ff, stg_in;
   logic [1:0] last_stg;
   logic [VEC_AW:0] o_ff, o_in, i_ff, i_in, k_ff, k_in;
   logic [DIM_W-1:0] j_ff, j_in;
   logic [1:0] dr_ff, dr_in;
   logic [VEC_AW:0] outer, inner, rows, cols;
   logic [VEC_AW-1:0] src_addr, dst_addr;
   logic [MAT_AW-1:0] m_addr;
   logic [1:0] msel, ssel, dsel;

   assign ctl.three = (fc_ff == 2'd3);
   assign ctl.r1 = r1; assign ctl.c1 = c1;
   assign ctl.r2 = r2; assign ctl.c2 = c2;
   assign ctl.r3 = r3; assign ctl.c3 = c3;

   // per-stage shape; sel codes: matrix 1..3, vector 0 x, 1 p, 2 q, 3 y
   always_comb begin
      last_stg = ctl.three ? 2'd2 : 2'd1;
      outer = '0; inner = '0; rows = '0; cols = '0;
      msel = 2'd1; ssel = 2'd0; dsel = 2'd3;
      if (ctl.three) begin
         case (stg_ff)
            2'd0: begin
               rows = (VEC_AW+1)'(ctl.r3); cols = (VEC_AW+1)'(ctl.c3);
               outer = (VEC_AW+1)'(ctl.c1) * (VEC_AW+1)'(ctl.c2);
               inner = (VEC_AW+1)'(1);
               msel = 2'd3; ssel = 2'd0; dsel = 2'd1;
            end
            2'd1: begin
               rows = (VEC_AW+1)'(ctl.r2); cols = (VEC_AW+1)'(ctl.c2);
               outer = (VEC_AW+1)'(ctl.c1); inner = (VEC_AW+1)'(ctl.r3);
               msel = 2'd2; ssel = 2'd1; dsel = 2'd2;
            end
            default: begin
               rows = (VEC_AW+1)'(ctl.r1); cols = (VEC_AW+1)'(ctl.c1);
               outer = (VEC_AW+1)'(1);
               inner = (VEC_AW+1)'(ctl.r2) * (VEC_AW+1)'(ctl.r3);
               msel = 2'd1; ssel = 2'd2; dsel = 2'd3;
            end
         endcase
      end else begin
         case (stg_ff)
            2'd0: begin
               rows = (VEC_AW+1)'(ctl.r2); cols = (VEC_AW+1)'(ctl.c2);
               outer = (VEC_AW+1)'(ctl.c1); inner = (VEC_AW+1)'(1);
               msel = 2'd2; ssel = 2'd0; dsel = 2'd1;
            end
            default: begin
               rows = (VEC_AW+1)'(ctl.r1); cols = (VEC_AW+1)'(ctl.c1);
               outer = (VEC_AW+1)'(1); inner = (VEC_AW+1)'(ctl.r2);
               msel = 2'd1; ssel = 2'd1; dsel = 2'd3;
            end
         endcase
      end
      m_addr   = MAT_AW'(i_ff * cols + (VEC_AW+1)'(j_ff));
      src_addr = VEC_AW'((o_ff * cols + (VEC_AW+1)'(j_ff)) * inner + k_ff);
      dst_addr = VEC_AW'((o_ff * rows + i_ff) * inner + k_ff);
   end

   // operand read, registered
   data_type opa_ff, opb_ff;
   logic     opv_ff, opv_in;
   logic signed [ACC_W-1:0] acc;
   logic     mac_clear;

   always_ff @(posedge clock) begin
      case (msel)
         2'd1:    opa_ff <= mem_a1[m_addr];
         2'd2:    opa_ff <= mem_a2[m_addr];
         default: opa_ff <= mem_a3[m_addr];
      endcase
      case (ssel)
         2'd0:    opb_ff <= mem_x[src_addr];
         2'd1:    opb_ff <= mem_p[src_addr];
         default: opb_ff <= mem_q[src_addr];
      endcase
      y_rd_ff <= mem_y[req_elem_index[VEC_AW-1:0]];
   end

   kmvp_mac u_mac (
      .clock (clock),
      .clear (mac_clear),
      .valid (opv_ff),
      .a     (opa_ff),
      .b     (opb_ff),
      .acc   (acc)
   );

   logic req_fire, rsp_free, wr_en;
   data_type wr_val;
   assign rsp_free = !rv_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !rsp_free || rd_pend_ff;
   assign req_fire = req_valid && !req_stall;

   logic [VEC_AW+1:0] ylimit;
   always_comb begin
      ylimit = (VEC_AW+2)'(r1) * (VEC_AW+2)'(r2);
      if (ctl.three) ylimit = (VEC_AW+2)'(ylimit * (VEC_AW+2)'(r3));
   end

   always_comb begin
      state_in = state_ff;
      stg_in = stg_ff; o_in = o_ff; i_in = i_ff; k_in = k_ff; j_in = j_ff;
      dr_in = dr_ff;
      opv_in = 1'b0;
      mac_clear = 1'b0;
      wr_en = 1'b0;
      rv_in = rv_ff && rsp_stall;
      rval_in = rval_ff; ridx_in = ridx_ff; rst_in = rst_ff;
      rd_pend_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (rd_pend_ff) begin
               rv_in = 1'b1; rval_in = y_rd_ff; rst_in = ST_READ_DATA;
            end else if (req_fire) begin
               ridx_in = req_elem_index;
               rval_in = '0;
               rst_in  = ST_RANGE_ERR;
               case (req_opcode)
                  OP_WRITE_A1, OP_WRITE_A2, OP_WRITE_A3:
                     rv_in = (32'(req_elem_index) >= MAT_DEPTH);
                  OP_WRITE_X:
                     rv_in = (32'(req_elem_index) >= VEC_DEPTH);
                  OP_COMPUTE: begin
                     stg_in = '0; state_in = S_SETUP;
                  end
                  OP_READ_Y: begin
                     if ((VEC_AW+2)'(req_elem_index) >= ylimit) rv_in = 1'b1;
                     else rd_pend_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         S_SETUP: begin
            o_in = '0; i_in = '0; k_in = '0; j_in = '0;
            mac_clear = 1'b1;
            state_in = S_FETCH;
         end
         S_FETCH: begin
            opv_in = 1'b1;
            if ((VEC_AW+1)'(j_ff) + 1'b1 == cols) begin
               dr_in = '0; state_in = S_DRAIN;
            end else j_in = j_ff + 1'b1;
         end
         S_DRAIN: begin
            dr_in = dr_ff + 1'b1;
            if (dr_ff == 2'd2) state_in = S_STORE;
         end
         S_STORE: begin
            wr_en = 1'b1;
            mac_clear = 1'b1;
            j_in = '0;
            state_in = S_FETCH;
            if (k_ff + 1'b1 != inner) k_in = k_ff + 1'b1;
            else begin
               k_in = '0;
               if (i_ff + 1'b1 != rows) i_in = i_ff + 1'b1;
               else begin
                  i_in = '0;
                  if (o_ff + 1'b1 != outer) o_in = o_ff + 1'b1;
                  else if (stg_ff == last_stg) state_in = S_DONE;
                  else begin
                     stg_in = stg_ff + 1'b1; state_in = S_SETUP;
                  end
               end
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rv_in = 1'b1; rval_in = '0; rst_in = ST_COMPUTED;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign wr_val = shift_sat(acc);

   always_ff @(posedge clock) begin
      if (req_fire && req_opcode == OP_WRITE_A1 && 32'(req_elem_index) < MAT_DEPTH)
         mem_a1[req_elem_index[MAT_AW-1:0]] <= sat_in(req_elem_value);
      if (req_fire && req_opcode == OP_WRITE_A2 && 32'(req_elem_index) < MAT_DEPTH)
         mem_a2[req_elem_index[MAT_AW-1:0]] <= sat_in(req_elem_value);
      if (req_fire && req_opcode == OP_WRITE_A3 && 32'(req_elem_index) < MAT_DEPTH)
         mem_a3[req_elem_index[MAT_AW-1:0]] <= sat_in(req_elem_value);
      if (req_fire && req_opcode == OP_WRITE_X && 32'(req_elem_index) < VEC_DEPTH)
         mem_x[req_elem_index[VEC_AW-1:0]] <= sat_in(req_elem_value);
      if (wr_en && dsel == 2'd1) mem_p[dst_addr] <= wr_val;
      if (wr_en && dsel == 2'd2) mem_q[dst_addr] <= wr_val;
      if (wr_en && dsel == 2'd3) mem_y[dst_addr] <= wr_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
         fc_ff <= 2'd2;
         r1_ff <= 4'd1; c1_ff <= 4'd1; r2_ff <= 4'd1;
         c2_ff <= 4'd1; r3_ff <= 4'd1; c3_ff <= 4'd1;
         opv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
         rd_pend_ff <= rd_pend_in;
         opv_ff <= opv_in;
         if (csr_write) begin
            case (csr_index)
               REG_FACTOR_COUNT: fc_ff <= (csr_data[1:0] == 2'd3) ? 2'd3 : 2'd2;
               REG_FIRST_ROWS:   r1_ff <= csr_data;
               REG_FIRST_COLS:   c1_ff <= csr_data;
               REG_SECOND_ROWS:  r2_ff <= csr_data;
               REG_SECOND_COLS:  c2_ff <= csr_data;
               REG_THIRD_ROWS:   r3_ff <= csr_data;
               REG_THIRD_COLS:   c3_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      stg_ff <= stg_in; o_ff <= o_in; i_ff <= i_in; k_ff <= k_in; j_ff <= j_in;
      dr_ff <= dr_in;
      rval_ff <= rval_in; ridx_ff <= ridx_in; rst_ff <= rst_in;
   end

   assign rsp_valid     = rv_ff;
   assign rsp_out_value = 32'(rval_ff);
   assign rsp_out_index = ridx_ff;
   assign rsp_status    = rst_ff;
endmodule

@@ src/kmvp_checker.sv @@
// Port-level checks for the Kronecker product core, bound to the top level.
module kmvp_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [2:0]  req_opcode,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic signed [31:0] rsp_out_value,
   input logic [1:0]  rsp_status
);
   import kmvp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped under stall");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_READ_DATA || rsp_status == ST_COMPUTED
                    || rsp_status == ST_RANGE_ERR)
      else $error("bad status");

   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_READ_DATA |-> rsp_out_value == 0)
      else $error("non-read response carries data");

   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_opcode == OP_COMPUTE |=> req_stall)
      else $error("accepted beat during compute");
endmodule

bind kronecker_matrix_vector_product_core kmvp_port_checks u_kmvp_port_checks (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_opcode(req_opcode), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_out_value(rsp_out_value), .rsp_status(rsp_status)
);

@@ dv/kmvp_checker.sv @@
// Watches the request and reply channels, predicts every reply and compares.
`timescale 1ns / 1ps
module kmvp_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [2:0]        req_opcode,
   input  logic [8:0]        req_elem_index,
   input  logic signed [31:0] req_elem_value,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic signed [31:0] rsp_out_value,
   input  logic [8:0]        rsp_out_index,
   input  logic [1:0]        rsp_status,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [3:0]        csr_data,
   output int                failures,
   output int                pending
);
   import kmvp_pkg::*;

   typedef struct {
      logic [31:0] value;
      logic [8:0]  index;
      logic [1:0]  status;
   } reply_type;

   localparam int BUF_X    = 0;
   localparam int BUF_MID  = 1;
   localparam int BUF_SCR  = 2;
   localparam int BUF_Y    = 3;

   localparam logic signed [127:0] Q_HI = 128'sd2147483647;
   localparam logic signed [127:0] Q_LO = -128'sd2147483648;

   reply_type         due_replies[$];
   logic signed [31:0] factors[3][MAT_DEPTH];
   logic signed [31:0] vectors[4][VEC_DEPTH];
   logic              three_way;
   logic [3:0]        dims[6];

   initial begin
      failures = 0;
      pending  = 0;
   end

   function automatic int span(input logic [3:0] v);
      if (v == 4'd0) return 1;
      if (int'(v) > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   // dst[o][i][k] = sum over j of factor[i][j] * src[o][j][k]
   function automatic void apply_factor(input int fi, input int r, input int c,
                                        input int sb, input int db,
                                        input int outer, input int inner);
      logic signed [127:0] acc;
      logic signed [127:0] sh;
      for (int o = 0; o < outer; o++)
         for (int i = 0; i < r; i++)
            for (int k = 0; k < inner; k++) begin
               acc = '0;
               for (int j = 0; j < c; j++)
                  acc = acc + factors[fi][i*c+j] * vectors[sb][(o*c+j)*inner+k];
               sh = acc >>> FRAC_BITS;
               if (sh > Q_HI) vectors[db][(o*r+i)*inner+k] = 32'sh7fffffff;
               else if (sh < Q_LO) vectors[db][(o*r+i)*inner+k] = 32'sh80000000;
               else vectors[db][(o*r+i)*inner+k] = sh[31:0];
            end
   endfunction

   function automatic void run_product();
      int r1, c1, r2, c2, r3, c3;
      r1 = span(dims[0]);
      c1 = span(dims[1]);
      r2 = span(dims[2]);
      c2 = span(dims[3]);
      r3 = span(dims[4]);
      c3 = span(dims[5]);
      if (three_way) begin
         apply_factor(2, r3, c3, BUF_X, BUF_MID, c1 * c2, 1);
         apply_factor(1, r2, c2, BUF_MID, BUF_SCR, c1, r3);
         apply_factor(0, r1, c1, BUF_SCR, BUF_Y, 1, r2 * r3);
      end else begin
         apply_factor(1, r2, c2, BUF_X, BUF_MID, c1, 1);
         apply_factor(0, r1, c1, BUF_MID, BUF_Y, 1, r2);
      end
   endfunction

   function automatic void forecast_reply();
      reply_type rep;
      int        idx;
      int        rows;
      idx        = int'(req_elem_index);
      rep.value  = '0;
      rep.index  = req_elem_index;
      rep.status = ST_RANGE_ERR;
      case (req_opcode)
         OP_WRITE_A1, OP_WRITE_A2, OP_WRITE_A3: begin
            if (idx < MAT_DEPTH) factors[int'(req_opcode)][idx] = req_elem_value;
            else due_replies.push_back(rep);
         end
         OP_WRITE_X: begin
            if (idx < VEC_DEPTH) vectors[BUF_X][idx] = req_elem_value;
            else due_replies.push_back(rep);
         end
         OP_COMPUTE: begin
            run_product();
            rep.status = ST_COMPUTED;
            due_replies.push_back(rep);
         end
         OP_READ_Y: begin
            rows = span(dims[0]) * span(dims[2]);
            if (three_way) rows = rows * span(dims[4]);
            if (idx < rows) begin
               rep.value  = vectors[BUF_Y][idx];
               rep.status = ST_READ_DATA;
            end
            due_replies.push_back(rep);
         end
         default: ;
      endcase
   endfunction

   task automatic report(input string what);
      $display("%0t mismatch: %s", $time, what);
      failures++;
   endtask

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         three_way = 1'b0;
         for (int i = 0; i < 6; i++) dims[i] = 4'd1;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_FACTOR_COUNT: three_way = (csr_data[1:0] == 2'd3);
               REG_FIRST_ROWS:   dims[0] = csr_data;
               REG_FIRST_COLS:   dims[1] = csr_data;
               REG_SECOND_ROWS:  dims[2] = csr_data;
               REG_SECOND_COLS:  dims[3] = csr_data;
               REG_THIRD_ROWS:   dims[4] = csr_data;
               REG_THIRD_COLS:   dims[5] = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) forecast_reply();
         if (rsp_valid && !rsp_stall) begin
            if (due_replies.size() == 0) begin
               report($sformatf("reply beat with nothing due, index %0d", rsp_out_index));
            end else begin
               want = due_replies.pop_front();
               if (rsp_out_value !== want.value)
                  report($sformatf("value %h, want %h at index %0d",
                                   rsp_out_value, want.value, want.index));
               if (rsp_out_index !== want.index)
                  report($sformatf("index %0d, want %0d", rsp_out_index, want.index));
               if (rsp_status !== want.status)
                  report($sformatf("status %0d, want %0d at index %0d",
                                   rsp_status, want.status, want.index));
            end
         end
      end
      pending = due_replies.size();
   end

endmodule

@@ dv/tb.sv @@
// Stimulus and verdict for the Kronecker matrix-vector product core.
`timescale 1ns / 1ps
module tb;
   import kmvp_pkg::*;

   localparam int QUIET_LIMIT = 100000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_opcode;
   logic [8:0]  req_elem_index;
   logic signed [31:0] req_elem_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic signed [31:0] rsp_out_value;
   logic [8:0]  rsp_out_index;
   logic [1:0]  rsp_status;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [3:0]  csr_data;
   int          failures;
   int          pending;

   bit          quiet;
   bit          hold_go;
   bit          hold_done;
   int          hold_left;
   int          quiet_cycles;

   int          r1, c1, r2, c2, r3, c3;
   bit          three;
   int          y_rows;
   bit          y_ready;

   kronecker_matrix_vector_product_core dut (.*);
   kmvp_checker chk (.*);

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_opcode     = OP_WRITE_A1;
      req_elem_index = '0;
      req_elem_value = '0;
      rsp_stall      = 1'b0;
      csr_write      = 1'b0;
      csr_index      = REG_FACTOR_COUNT;
      csr_data       = '0;
      quiet          = 1'b0;
      hold_go        = 1'b0;
      hold_done      = 1'b0;
      hold_left      = 0;
      quiet_cycles   = 0;
   end

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_go && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= 80;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(0, 99) < 28);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic int span(input logic [3:0] v);
      if (v == 4'd0) return 1;
      if (int'(v) > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   function automatic logic [31:0] pick_value();
      logic [31:0] s;
      case ($urandom_range(0, 9))
         0: s = 32'h7fffffff;
         1: s = 32'h80000000;
         2: s = '0;
         3, 4, 5, 6: s = $urandom_range(0, 262143) - 32'h20000;
         default: s = $urandom;
      endcase
      return s;
   endfunction

   task automatic offer_beat(input logic [2:0] op, input int idx, input logic [31:0] val);
      while (!quiet && $urandom_range(0, 99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_elem_index <= 9'(idx);
      req_elem_value <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == OP_COMPUTE) y_ready = 1'b1;
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic put_reg(input logic [2:0] idx, input logic [3:0] d);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [3:0] fc, input logic [3:0] a, input logic [3:0] b,
                             input logic [3:0] c, input logic [3:0] d,
                             input logic [3:0] e, input logic [3:0] f);
      put_reg(REG_FACTOR_COUNT, fc);
      put_reg(REG_FIRST_ROWS, a);
      put_reg(REG_FIRST_COLS, b);
      put_reg(REG_SECOND_ROWS, c);
      put_reg(REG_SECOND_COLS, d);
      put_reg(REG_THIRD_ROWS, e);
      put_reg(REG_THIRD_COLS, f);
      csr_write <= 1'b0;
      three = (fc[1:0] == 2'd3);
      r1 = span(a);
      c1 = span(b);
      r2 = span(c);
      c2 = span(d);
      r3 = span(e);
      c3 = span(f);
      y_rows  = three ? r1 * r2 * r3 : r1 * r2;
      y_ready = 1'b0;
   endtask

   task automatic run_phase(input logic [3:0] fc, input logic [3:0] a, input logic [3:0] b,
                            input logic [3:0] c, input logic [3:0] d,
                            input logic [3:0] e, input logic [3:0] f,
                            input int count, input int mode);
      int n;
      int op;
      drain_replies();
      set_config(fc, a, b, c, d, e, f);
      for (int i = 0; i < r1 * c1; i++) offer_beat(OP_WRITE_A1, i, pick_value());
      for (int i = 0; i < r2 * c2; i++) offer_beat(OP_WRITE_A2, i, pick_value());
      if (three)
         for (int i = 0; i < r3 * c3; i++) offer_beat(OP_WRITE_A3, i, pick_value());
      for (int i = 0; i < c1 * c2 * (three ? c3 : 1); i++)
         offer_beat(OP_WRITE_X, i, pick_value());
      offer_beat(OP_COMPUTE, $urandom_range(0, 511), $urandom);
      if (mode == 1) hold_go = 1'b1;
      if (mode == 3) quiet = 1'b1;
      n = 0;
      while (n < count) begin
         if (mode == 2 && n == count / 2) drain_replies();
         op = $urandom_range(0, 99);
         if (op < 45) begin
            op = $urandom_range(0, 3);
            if (op == 3)
               offer_beat(OP_WRITE_X, $urandom_range(0, 511), pick_value());
            else if ($urandom_range(0, 4) == 0)
               offer_beat(3'(op), $urandom_range(MAT_DEPTH, 511), pick_value());
            else
               offer_beat(3'(op), $urandom_range(0, MAT_DEPTH - 1), pick_value());
            n++;
         end else if (op < 88) begin
            if (y_ready && (y_rows == VEC_DEPTH || $urandom_range(0, 3) != 0))
               offer_beat(OP_READ_Y, $urandom_range(0, y_rows - 1), $urandom);
            else if (y_rows < VEC_DEPTH)
               offer_beat(OP_READ_Y, $urandom_range(y_rows, 511), $urandom);
            else
               offer_beat(OP_COMPUTE, $urandom_range(0, 511), $urandom);
            n++;
         end else if (op < 93) begin
            offer_beat(OP_COMPUTE, $urandom_range(0, 511), $urandom);
            n++;
         end else begin
            offer_beat(3'($urandom_range(6, 7)), $urandom_range(0, 511), $urandom);
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      r1 = 1; c1 = 1; r2 = 1; c2 = 1; r3 = 1; c3 = 1;
      three = 1'b0; y_rows = 1; y_ready = 1'b0;
      @(posedge clock);

      offer_beat(OP_WRITE_A1, 0, 32'h7fffffff);
      offer_beat(OP_WRITE_A2, 0, 32'h7fffffff);
      offer_beat(OP_WRITE_X, 0, 32'h7fffffff);
      offer_beat(OP_COMPUTE, 0, 32'h0);
      offer_beat(OP_READ_Y, 0, 32'h0);
      offer_beat(OP_READ_Y, 1, 32'h0);
      offer_beat(OP_READ_Y, 511, 32'hffffffff);
      offer_beat(OP_WRITE_A1, 64, 32'h12345678);
      offer_beat(OP_WRITE_A2, 511, 32'h0);
      offer_beat(OP_WRITE_A3, 511, 32'h80000000);
      offer_beat(OP_WRITE_A3, 0, 32'h80000000);
      offer_beat(OP_WRITE_X, 511, 32'h80000000);
      offer_beat(OP_WRITE_A1, 0, 32'h80000000);
      offer_beat(OP_COMPUTE, 511, 32'hffffffff);
      offer_beat(OP_READ_Y, 0, 32'h0);
      offer_beat(OP_WRITE_A2, 0, 32'h80000000);
      offer_beat(OP_COMPUTE, 7, 32'h0);
      offer_beat(OP_READ_Y, 0, 32'h0);
      offer_beat(3'd6, 3, 32'h0);
      offer_beat(3'd7, 256, 32'hffffffff);
      offer_beat(OP_WRITE_X, 0, 32'h0);
      offer_beat(OP_WRITE_A2, 0, 32'h00010000);
      offer_beat(OP_WRITE_A1, 0, 32'hfffe0000);
      offer_beat(OP_COMPUTE, 0, 32'h0);
      offer_beat(OP_READ_Y, 0, 32'h0);

      run_phase(4'd2, 4'd4, 4'd3, 4'd2, 4'd5, 4'd0, 4'd0, 80, 1);
      run_phase(4'd3, 4'd2, 4'd3, 4'd3, 4'd2, 4'd2, 4'd2, 80, 2);
      run_phase(4'd2, 4'd8, 4'd8, 4'd8, 4'd8, 4'd15, 4'd15, 80, 3);
      run_phase(4'd3, 4'd8, 4'd2, 4'd8, 4'd2, 4'd8, 4'd2, 80, 0);
      run_phase(4'd0, 4'd0, 4'd15, 4'd1, 4'd9, 4'd3, 4'd7, 80, 0);
      run_phase(4'd1, 4'd5, 4'd2, 4'd7, 4'd4, 4'd6, 4'd1, 80, 0);
      run_phase(4'd3, 4'd15, 4'd0, 4'd10, 4'd5, 4'd12, 4'd3, 80, 0);
      run_phase(4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 80, 0);

      drain_replies();
      repeat (20) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
